/* hw/rtl/srss_pkg.sv */
package srss_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int MAX_ITEMS_DEF   = 16;
  localparam logic [4:0] LIMIT_RESET = 5'd16;

  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_ADD      = 2'd1;
  localparam logic [1:0] ACT_LOOKUP   = 2'd2;
  localparam logic [1:0] ACT_QUERY    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_SETFULL  = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] entry_id;
    logic [63:0] item_id;
    logic [7:0]  entry_type;
    logic [31:0] entry_capacity;
    logic [63:0] policy_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        entry_found;
    logic        knows_item;
    logic [7:0]  found_type;
    logic [31:0] found_capacity;
    logic [63:0] found_policy;
    logic [4:0]  found_holdings;
  } out_t;

endpackage

/* hw/rtl/srss_ram.sv */
module srss_ram #(
  parameter int W  = 64,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/sorted_registry_with_sorted_sets_unit.sv */
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall   in_t  (action, ids, attributes)
// out_     output     out_valid/out_stall out_t (status, found fields)
// cfg_     input      cfg_we              institution limit, 5 bits
//
// One item is worked on at a time. The entry search visits each entry in a
// read state and then a compare state, a register action adds a read and a
// write state per entry moved, an add or query adds a read and a check state
// per item visited, and an add a read and a write state per item moved.
// The entry and item memories are read through a registered port.
// Reset is synchronous, clears the entry count and the control state and
// returns the limit to sixteen; the memories need no clearing. A stalled
// result is held in the output register, and the next item is taken once the
// current one has finished.
module sorted_registry_with_sorted_sets_unit
  import srss_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int ICW = $clog2(MAX_ITEMS + 1);
  localparam int ID  = MAX_ENTRIES * MAX_ITEMS;
  localparam int IAW = (ID > 1) ? $clog2(ID) : 1;

  // Entries carry a slot number that names their item set in the item memory.
  // Slots are handed out in order of registration and never move, so a
  // register action shifts only the entry records and not the item sets.
  typedef struct packed {
    logic [63:0]    id;
    logic [7:0]     etype;
    logic [31:0]    cap;
    logic [63:0]    pol;
    logic [ICW-1:0] cnt;
    logic [EAW-1:0] slot;
  } erec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EREAD, S_ECHK, S_DISPATCH, S_ESH_RD, S_ESH_WR, S_EINS,
    S_IREAD, S_ICHK, S_ISH_RD, S_ISH_WR, S_IINS, S_DONE
  } state_t;

  state_t         st_r;
  in_t            req_r;
  logic [4:0]     limit_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  e_r;
  logic [CW-1:0]  idx_r;
  logic [ICW-1:0] i_r;
  logic [ICW-1:0] ipos_r;
  logic           hit_r;
  logic           knows_r;
  logic [2:0]     status_r;
  erec_t          rec_r;
  logic           out_valid_r;
  out_t           out_r;

  logic           e_we;
  logic [EAW-1:0] e_waddr;
  logic [EAW-1:0] e_raddr;
  erec_t          e_wdata;
  erec_t          e_rdata;
  logic           i_we;
  logic [IAW-1:0] i_waddr;
  logic [IAW-1:0] i_raddr;
  logic [63:0]    i_wdata;
  logic [63:0]    i_rdata;
  logic [IAW-1:0] ibase;
  logic [31:0]    lim;
  logic [CW-1:0]  e_dec;
  logic [ICW-1:0] i_dec;
  logic [ICW-1:0] cnt_inc;
  logic           show_attr;

  srss_ram #(.W($bits(erec_t)), .D(MAX_ENTRIES)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  srss_ram #(.W(64), .D(ID)) u_item_ram (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr(i_raddr), .rdata(i_rdata)
  );

  assign lim     = (32'(limit_r) < MAX_ENTRIES) ? 32'(limit_r) : 32'(MAX_ENTRIES);
  assign ibase   = IAW'(rec_r.slot) * IAW'(MAX_ITEMS);
  assign e_dec   = e_r - CW'(1);
  assign i_dec   = i_r - ICW'(1);
  assign cnt_inc = rec_r.cnt + ICW'(1);
  // Only a lookup that found its entry reports the stored attributes.
  assign show_attr = hit_r && (req_r.action == ACT_LOOKUP);

  // Memory ports follow the sequencer state. Reads are registered and land in
  // the next cycle, which is when the check or write-back state looks at them.
  always_comb begin
    e_we    = 1'b0;
    e_waddr = e_r[EAW-1:0];
    e_wdata = e_rdata;
    e_raddr = e_r[EAW-1:0];
    i_we    = 1'b0;
    i_waddr = ibase + IAW'(i_r);
    i_wdata = i_rdata;
    i_raddr = ibase + IAW'(i_r);
    unique case (st_r)
      S_ESH_RD: e_raddr = e_dec[EAW-1:0];
      S_ESH_WR: e_we = 1'b1;
      S_EINS: begin
        e_we    = 1'b1;
        e_waddr = idx_r[EAW-1:0];
        e_wdata = '{id: req_r.entry_id, etype: req_r.entry_type,
                    cap: req_r.entry_capacity, pol: req_r.policy_id,
                    cnt: '0, slot: count_r[EAW-1:0]};
      end
      S_ISH_RD: i_raddr = ibase + IAW'(i_dec);
      S_ISH_WR: i_we = 1'b1;
      S_IINS: begin
        i_we    = 1'b1;
        i_waddr = ibase + IAW'(ipos_r);
        i_wdata = req_r.item_id;
        e_we    = 1'b1;
        e_waddr = idx_r[EAW-1:0];
        e_wdata = rec_r;
        e_wdata.cnt = cnt_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      limit_r     <= LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      // In the finishing state the result register is handled there.
      if (out_valid_r && !out_stall && st_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r    <= in_data;
            e_r      <= '0;
            hit_r    <= 1'b0;
            knows_r  <= 1'b0;
            status_r <= ST_OK;
            st_r     <= S_EREAD;
          end
        end
        S_EREAD: begin
          if (e_r >= count_r) begin
            idx_r <= e_r;
            st_r  <= S_DISPATCH;
          end else begin
            st_r <= S_ECHK;
          end
        end
        S_ECHK: begin
          if (e_rdata.id == req_r.entry_id) begin
            hit_r <= 1'b1;
            rec_r <= e_rdata;
            idx_r <= e_r;
            st_r  <= S_DISPATCH;
          end else if (e_rdata.id > req_r.entry_id) begin
            idx_r <= e_r;
            st_r  <= S_DISPATCH;
          end else begin
            e_r  <= e_r + CW'(1);
            st_r <= S_EREAD;
          end
        end
        S_DISPATCH: begin
          i_r <= '0;
          if (req_r.action == ACT_REGISTER) begin
            if (32'(count_r) >= lim) begin
              status_r <= ST_FULL;
              st_r     <= S_DONE;
            end else if (hit_r) begin
              status_r <= ST_DUP;
              st_r     <= S_DONE;
            end else begin
              e_r  <= count_r;
              st_r <= S_ESH_RD;
            end
          end else if (!hit_r) begin
            status_r <= ST_NOTFOUND;
            st_r     <= S_DONE;
          end else if (req_r.action == ACT_ADD && 32'(rec_r.cnt) >= MAX_ITEMS) begin
            status_r <= ST_SETFULL;
            st_r     <= S_DONE;
          end else if (req_r.action == ACT_LOOKUP) begin
            st_r <= S_DONE;
          end else begin
            st_r <= S_IREAD;
          end
        end
        S_ESH_RD: st_r <= (e_r > idx_r) ? S_ESH_WR : S_EINS;
        S_ESH_WR: begin
          e_r  <= e_dec;
          st_r <= S_ESH_RD;
        end
        S_EINS: begin
          count_r <= count_r + CW'(1);
          st_r    <= S_DONE;
        end
        S_IREAD: begin
          if (i_r >= rec_r.cnt) begin
            ipos_r <= i_r;
            st_r   <= (req_r.action == ACT_ADD) ? S_ISH_RD : S_DONE;
          end else begin
            st_r <= S_ICHK;
          end
        end
        S_ICHK: begin
          if (i_rdata == req_r.item_id) begin
            knows_r <= (req_r.action == ACT_QUERY);
            st_r    <= S_DONE;
          end else if (i_rdata > req_r.item_id && req_r.action == ACT_ADD) begin
            ipos_r <= i_r;
            i_r    <= rec_r.cnt;
            st_r   <= S_ISH_RD;
          end else begin
            i_r  <= i_r + ICW'(1);
            st_r <= S_IREAD;
          end
        end
        S_ISH_RD: st_r <= (i_r > ipos_r) ? S_ISH_WR : S_IINS;
        S_ISH_WR: begin
          i_r  <= i_dec;
          st_r <= S_ISH_RD;
        end
        S_IINS: begin
          rec_r.cnt <= cnt_inc;
          st_r      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r          <= 1'b1;
            out_r.status         <= status_r;
            out_r.entry_found    <= hit_r;
            out_r.knows_item     <= knows_r;
            out_r.found_type     <= show_attr ? rec_r.etype : 8'd0;
            out_r.found_capacity <= show_attr ? rec_r.cap : 32'd0;
            out_r.found_policy   <= show_attr ? rec_r.pol : 64'd0;
            out_r.found_holdings <= hit_r ? 5'(rec_r.cnt) : 5'd0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The table never grows past its built depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_ENTRIES)
    else $error("entry count beyond table depth");

  // A new result only appears after the finishing state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_DONE))
    else $error("result raised outside finishing state");

  // A found entry never reports not-found.
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.entry_found && out_r.status == ST_NOTFOUND))
    else $error("found entry reported as missing");

  // Membership is only claimed for an entry that was found.
  a_knows_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.knows_item) |-> (out_r.entry_found && out_r.status == ST_OK))
    else $error("item known without its entry");

endmodule

/* tb/sorted_registry_with_sorted_sets_unit_tb.sv */
`timescale 1ns / 1ps

module sorted_registry_with_sorted_sets_unit_tb;
  import srss_pkg::*;

  // Registry scoreboard: a behavioral copy of the table and its item sets.
  // Inputs are applied in the order they are accepted, and the outcome of
  // each one is queued until the block returns its result item.
  class registry_board;
    logic [63:0] ids [16];
    logic [7:0]  types [16];
    logic [31:0] caps [16];
    logic [63:0] pols [16];
    int          counts [16];
    logic [63:0] sets [16][16];
    int          n_entries;
    logic [4:0]  limit;
    out_t        pending [$];
    int          errors;
    int          checked;

    function new();
      n_entries = 0;
      limit = LIMIT_RESET;
      errors = 0;
      checked = 0;
    endfunction

    // Applies one accepted input to the table and queues the expected result.
    function void note_input(in_t x);
      out_t r;
      int lim;
      int idx;
      int pos;
      bit hit;
      r = '0;
      lim = (limit < 16) ? limit : 16;
      hit = 0;
      idx = 0;
      while (idx < n_entries) begin
        if (ids[idx] == x.entry_id) begin
          hit = 1;
          break;
        end
        if (ids[idx] > x.entry_id) break;
        idx++;
      end
      if (x.action == ACT_REGISTER) begin
        if (n_entries >= lim) begin
          r.status = ST_FULL;
        end else if (hit) begin
          r.status = ST_DUP;
        end else begin
          for (int k = n_entries; k > idx; k--) begin
            ids[k] = ids[k-1];
            types[k] = types[k-1];
            caps[k] = caps[k-1];
            pols[k] = pols[k-1];
            counts[k] = counts[k-1];
            sets[k] = sets[k-1];
          end
          ids[idx] = x.entry_id;
          types[idx] = x.entry_type;
          caps[idx] = x.entry_capacity;
          pols[idx] = x.policy_id;
          counts[idx] = 0;
          n_entries++;
        end
      end else if (!hit) begin
        r.status = ST_NOTFOUND;
      end else if (x.action == ACT_ADD) begin
        if (counts[idx] >= 16) begin
          r.status = ST_SETFULL;
        end else begin
          pos = 0;
          while (pos < counts[idx] && sets[idx][pos] < x.item_id) pos++;
          // An item already in the set is accepted with no change.
          if (!(pos < counts[idx] && sets[idx][pos] == x.item_id)) begin
            for (int k = counts[idx]; k > pos; k--) sets[idx][k] = sets[idx][k-1];
            sets[idx][pos] = x.item_id;
            counts[idx]++;
          end
        end
      end else if (x.action == ACT_LOOKUP) begin
        r.found_type = types[idx];
        r.found_capacity = caps[idx];
        r.found_policy = pols[idx];
      end else begin
        for (int k = 0; k < counts[idx]; k++)
          if (sets[idx][k] == x.item_id) r.knows_item = 1;
      end
      if (hit) begin
        r.entry_found = 1;
        r.found_holdings = counts[idx][4:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_t a);
      out_t e;
      if (pending.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.entry_found !== e.entry_found) begin
        $error("entry_found exp %0d got %0d", e.entry_found, a.entry_found); errors++;
      end
      if (a.knows_item !== e.knows_item) begin
        $error("knows_item exp %0d got %0d", e.knows_item, a.knows_item); errors++;
      end
      if (a.found_type !== e.found_type) begin
        $error("found_type exp %0h got %0h", e.found_type, a.found_type); errors++;
      end
      if (a.found_capacity !== e.found_capacity) begin
        $error("found_capacity exp %0h got %0h", e.found_capacity, a.found_capacity);
        errors++;
      end
      if (a.found_policy !== e.found_policy) begin
        $error("found_policy exp %0h got %0h", e.found_policy, a.found_policy); errors++;
      end
      if (a.found_holdings !== e.found_holdings) begin
        $error("found_holdings exp %0d got %0d", e.found_holdings, a.found_holdings);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  registry_board board;
  int          sent_items;
  // Ids sent in register actions, used to aim actions at entries that may exist.
  logic [63:0] known_ids [$];
  // Eight items in a pool so that adds and queries hit often.
  logic [63:0] item_pool [8];

  sorted_registry_with_sorted_sets_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sends one item, after a random gap, and holds it until it is accepted.
  // With no gap the next item follows on the edge that took the last one.
  task automatic send_item(in_t x);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(x);
    sent_items++;
    if (x.action == ACT_REGISTER) known_ids.push_back(x.entry_id);
  endtask

  task automatic send_action(logic [1:0] act, logic [63:0] eid, logic [63:0] iid);
    in_t x;
    x.action = act;
    x.entry_id = eid;
    x.item_id = iid;
    x.entry_type = 8'($urandom);
    x.entry_capacity = $urandom;
    x.policy_id = rand64();
    send_item(x);
  endtask

  // Waits until every expected result has come back, then lets the
  // block settle before the limit register changes.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.limit = v;
  endtask

  // The receiver stalls for a random count before each result item.
  initial begin
    int hold;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      hold = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(out_data);
    end
  end

  // Random phase: actions mostly aimed at known ids, with random and small ids
  // as noise, and items mostly taken from the pool.
  task automatic random_phase(int count);
    logic [63:0] eid;
    logic [63:0] iid;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (known_ids.size() != 0 && r < 85)
        eid = known_ids[$urandom_range(0, known_ids.size() - 1)];
      else if (r < 92)
        eid = rand64();
      else
        eid = {60'd0, 4'($urandom)};
      if ($urandom_range(0, 4) == 0) iid = rand64();
      else iid = item_pool[$urandom_range(0, 7)];
      r = $urandom_range(0, 99);
      if (r < 15) send_action(ACT_REGISTER, eid, iid);
      else if (r < 55) send_action(ACT_ADD, eid, iid);
      else if (r < 75) send_action(ACT_LOOKUP, eid, iid);
      else send_action(ACT_QUERY, eid, iid);
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sent_items = 0;
    for (int k = 0; k < 8; k++) item_pool[k] = rand64();
    item_pool[0] = '0;
    item_pool[1] = '1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extreme ids, missing entry, duplicates, full set.
    send_action(ACT_LOOKUP, 64'd5, 64'd0);
    send_action(ACT_REGISTER, '1, '1);
    send_action(ACT_REGISTER, '0, '0);
    send_action(ACT_REGISTER, 64'h8000_0000_0000_0000, '0);
    send_action(ACT_REGISTER, '0, '0);
    send_action(ACT_LOOKUP, '1, '0);
    send_action(ACT_QUERY, '0, '1);
    for (int k = 0; k < 17; k++)
      send_action(ACT_ADD, '0, (k == 16) ? 64'd3 : {$urandom, 28'd0, 4'(15 - k)});
    send_action(ACT_QUERY, '0, 64'd3);
    send_action(ACT_ADD, '1, '1);
    send_action(ACT_ADD, '1, '1);
    send_action(ACT_QUERY, '1, '1);
    send_action(ACT_QUERY, 64'd7, '1);

    // Pause until all results are back, then run through limit settings.
    write_limit(5'd2);
    send_action(ACT_REGISTER, 64'd77, 64'd0);
    send_action(ACT_LOOKUP, '0, 64'd0);
    write_limit(5'd0);
    send_action(ACT_REGISTER, 64'd78, 64'd0);
    write_limit(5'd31);
    random_phase(500);
    write_limit(5'd16);
    known_ids.delete();
    random_phase(500);
    write_limit(5'd20);
    random_phase(450);
    write_limit(5'd5);
    random_phase(450);

    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d items and checked %0d results over limits 0 to 31,",
             sent_items, board.checked);
    $display("with full tables, full item sets, duplicates and missing entries.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
